>>> rtl/core/pns_pkg.sv
package pns_pkg;

  localparam int DIM_W         = 11;
  localparam int SIDE_W        = 8;
  localparam int OUTPUT_SIDE   = 256;
  localparam int ADDR_W        = 2 * DIM_W + 1;
  localparam int TARGET_W      = 17;
  localparam int COLOR_W       = 32;
  localparam int IDX_W         = 8;
  localparam int PAL_DEPTH     = 256;
  localparam int PAL_AW        = 8;
  localparam int SRC_BYTES_DEF = 131072;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;

  localparam logic [DIM_W-1:0] COLS_RESET = 11'd320;
  localparam logic [DIM_W-1:0] ROWS_RESET = 11'd240;

  typedef enum logic [1:0] {
    OP_PAL_WR = 2'd0,
    OP_SRC_WR = 2'd1,
    OP_PIXEL  = 2'd2
  } op_t;

  typedef enum logic {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               live;
    op_t                op;
    logic               ok;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] value;
  } req_t;

endpackage

>>> rtl/core/paletted_nearest_scaler_top.sv
// paletted nearest-neighbor scaler
// request channel: start with operation, target_address, write_value, out_row
// and out_column; a request is taken at every clock edge where start is high
// and busy is low. busy stays low, so one request enters every cycle.
// palette writes and source byte writes return nothing; a pixel request
// returns one result, done high for one cycle with pixel_color and
// pixel_valid, at the end of the pipeline below.
// pipeline: coordinate map, address multiply, source store read, palette
// read. each store is touched by one stage only, so requests see every
// earlier write without forwarding.
// throughput: one request per cycle, set by the single read/write port of
// each store.
// geometry registers over apb: source_columns at 0x0, source_rows at 0x4;
// change them only with no request in flight.
// reset clears the pipeline and the geometry registers (320 x 240); the
// stores keep their contents and must be written before they are read.
// the receiver cannot stall: each result is valid for exactly one cycle.
module paletted_nearest_scaler_top
  import pns_pkg::*;
#(
  parameter int SOURCE_STORE_BYTES = SRC_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [TARGET_W-1:0] target_address,
  input  logic [COLOR_W-1:0]  write_value,
  input  logic [SIDE_W-1:0]   out_row,
  input  logic [SIDE_W-1:0]   out_column,
  output logic                done,
  output logic [COLOR_W-1:0]  pixel_color,
  output logic                pixel_valid,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  logic             accept;
  logic             cfg_wr;
  reg_idx_t         reg_idx;
  logic [DIM_W-1:0] source_columns;
  logic [DIM_W-1:0] source_rows;
  req_t             req_s2;
  req_t             req_s3;
  logic [IDX_W-1:0] index;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_columns <= COLS_RESET;
      source_rows    <= ROWS_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COLS: source_columns <= pwdata[DIM_W-1:0];
        REG_ROWS: source_rows    <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COLS: prdata = APB_DW'(source_columns);
      REG_ROWS: prdata = APB_DW'(source_rows);
      default:  prdata = '0;
    endcase
  end

  pns_addr_gen #(
    .SOURCE_STORE_BYTES(SOURCE_STORE_BYTES)
  ) u_addr_gen (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (operation),
    .target_address(target_address),
    .write_value   (write_value),
    .out_row       (out_row),
    .out_column    (out_column),
    .source_columns(source_columns),
    .source_rows   (source_rows),
    .req           (req_s2)
  );

  pns_src_mem #(
    .SOURCE_STORE_BYTES(SOURCE_STORE_BYTES)
  ) u_src_mem (
    .clk    (clk),
    .rst    (rst),
    .req_in (req_s2),
    .req_out(req_s3),
    .index  (index)
  );

  pns_pal_mem u_pal_mem (
    .clk        (clk),
    .rst        (rst),
    .req_in     (req_s3),
    .index      (index),
    .done       (done),
    .pixel_color(pixel_color),
    .pixel_valid(pixel_valid)
  );

  a_done_from_pixel_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && operation == OP_PIXEL, 4))
    else $error("result without a pixel request four cycles earlier");

  a_pixel_request_answered: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PIXEL) |-> ##4 done)
    else $error("pixel request not answered after four cycles");

  a_row_outside_invalid: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PIXEL && DIM_W'(out_row) >= source_rows)
      |-> ##4 (done && !pixel_valid && pixel_color == '0))
    else $error("row outside scaled height returned as valid");

  a_no_result_for_writes: assert property (@(posedge clk) disable iff (rst)
    (accept && operation != OP_PIXEL) |-> ##4 !done)
    else $error("write or unused operation produced a result");

endmodule

>>> rtl/core/pns_addr_gen.sv
module pns_addr_gen
  import pns_pkg::*;
#(
  parameter int SOURCE_STORE_BYTES = SRC_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          operation,
  input  logic [TARGET_W-1:0] target_address,
  input  logic [COLOR_W-1:0]  write_value,
  input  logic [SIDE_W-1:0]   out_row,
  input  logic [SIDE_W-1:0]   out_column,
  input  logic [DIM_W-1:0]    source_columns,
  input  logic [DIM_W-1:0]    source_rows,
  output req_t                req
);

  logic [DIM_W+SIDE_W:0]   col_prod;
  logic [DIM_W+SIDE_W-1:0] row_prod;
  logic [DIM_W-1:0]        row_next;
  logic [DIM_W-1:0]        col_next;
  logic                    row_ok_next;
  logic                    live_next;

  logic                    s1_live;
  op_t                     s1_op;
  logic                    s1_row_ok;
  logic [DIM_W-1:0]        s1_row;
  logic [DIM_W-1:0]        s1_col;
  logic [TARGET_W-1:0]     s1_target;
  logic [COLOR_W-1:0]      s1_value;

  logic [2*DIM_W-1:0]      addr_prod;
  logic [ADDR_W-1:0]       pix_addr;
  logic                    addr_in;
  req_t                    req_next;

  // stage 0: source column and row
  assign col_prod    = (DIM_W+SIDE_W+1)'(source_columns) *
                       (DIM_W+SIDE_W+1)'({out_column, 1'b1});
  assign row_prod    = (DIM_W+SIDE_W)'(source_rows) * (DIM_W+SIDE_W)'(out_row);
  assign col_next    = col_prod[DIM_W+SIDE_W:SIDE_W+1];
  assign row_next    = (source_rows <= DIM_W'(OUTPUT_SIDE)) ? DIM_W'(out_row)
                                                           : row_prod[DIM_W+SIDE_W-1:SIDE_W];
  assign row_ok_next = DIM_W'(out_row) < source_rows;
  assign live_next   = accept && (operation == OP_PAL_WR || operation == OP_SRC_WR ||
                                  operation == OP_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_live <= 1'b0;
    end else begin
      s1_live <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_op     <= op_t'(operation);
    s1_row_ok <= row_ok_next;
    s1_row    <= row_next;
    s1_col    <= col_next;
    s1_target <= target_address;
    s1_value  <= write_value;
  end

  // stage 1: byte address in the source store
  assign addr_prod = (2*DIM_W)'(source_columns) * (2*DIM_W)'(s1_row);
  assign pix_addr  = ADDR_W'(addr_prod) + ADDR_W'(s1_col);
  assign addr_in   = 32'(pix_addr) < 32'(SOURCE_STORE_BYTES);

  always_comb begin
    req_next       = '0;
    req_next.live  = s1_live;
    req_next.op    = s1_op;
    req_next.value = s1_value;
    case (s1_op)
      OP_PAL_WR: begin
        req_next.ok   = s1_target[TARGET_W-1:PAL_AW] == '0;
        req_next.addr = ADDR_W'(s1_target);
      end
      OP_SRC_WR: begin
        req_next.ok   = 32'(s1_target) < 32'(SOURCE_STORE_BYTES);
        req_next.addr = ADDR_W'(s1_target);
      end
      default: begin
        req_next.ok   = s1_row_ok && addr_in;
        req_next.addr = pix_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req.live <= 1'b0;
    end else begin
      req.live <= req_next.live;
    end
    req.op    <= req_next.op;
    req.ok    <= req_next.ok;
    req.addr  <= req_next.addr;
    req.value <= req_next.value;
  end

endmodule

>>> rtl/core/pns_src_mem.sv
module pns_src_mem
  import pns_pkg::*;
#(
  parameter int SOURCE_STORE_BYTES = SRC_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             req_in,
  output req_t             req_out,
  output logic [IDX_W-1:0] index
);

  localparam int AW = $clog2(SOURCE_STORE_BYTES);

  logic [IDX_W-1:0] mem [SOURCE_STORE_BYTES];
  logic [AW-1:0]    mem_addr;

  assign mem_addr = req_in.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (req_in.live && req_in.op == OP_SRC_WR && req_in.ok) begin
      mem[mem_addr] <= req_in.value[IDX_W-1:0];
    end
    index <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_out.live <= 1'b0;
    end else begin
      req_out.live <= req_in.live;
    end
    req_out.op    <= req_in.op;
    req_out.ok    <= req_in.ok;
    req_out.addr  <= req_in.addr;
    req_out.value <= req_in.value;
  end

endmodule

>>> rtl/core/pns_pal_mem.sv
module pns_pal_mem
  import pns_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  req_t               req_in,
  input  logic [IDX_W-1:0]   index,
  output logic               done,
  output logic [COLOR_W-1:0] pixel_color,
  output logic               pixel_valid
);

  logic [COLOR_W-1:0] pal [PAL_DEPTH];
  logic [COLOR_W-1:0] pal_q;
  logic               ok_q;

  always_ff @(posedge clk) begin
    if (req_in.live && req_in.op == OP_PAL_WR && req_in.ok) begin
      pal[req_in.addr[PAL_AW-1:0]] <= req_in.value;
    end
    pal_q <= pal[index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_in.live && req_in.op == OP_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    ok_q <= req_in.ok && req_in.op == OP_PIXEL;
  end

  assign pixel_color = ok_q ? pal_q : '0;
  assign pixel_valid = ok_q;

endmodule
